// ===== hw/rtl/dsfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfe_pkg - shared definitions for the DShot frame encoder
// Field widths, register indexes, reset values and the bit timing table.
// ----------------------------------------------------------------------------
package dsfe_pkg;

  // Frame geometry
  localparam int FRAME_BITS = 16;
  localparam int VALUE_W    = 11;
  localparam int WORD_W     = VALUE_W + 1;
  localparam int CSUM_W     = 4;
  localparam int FRAME_W    = WORD_W + CSUM_W;
  localparam int CNT_W      = 5;

  // Symbol payload widths
  localparam int TICK_W   = 15;
  localparam int LOW_W    = 6;
  localparam int HIGH_W   = 6;
  localparam int PERIOD_W = 7;
  localparam int SPEED_W  = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS  = 2'd3;

  localparam logic [SPEED_W-1:0] RST_SPEED_MODE   = 3'd0;
  localparam logic [VALUE_W-1:0] RST_THROTTLE_MIN = 11'd48;
  localparam logic [VALUE_W-1:0] RST_THROTTLE_MAX = 11'd2047;
  localparam logic [TICK_W-1:0]  RST_PAUSE_TICKS  = 15'd1000;

  // Speed codes
  localparam logic [SPEED_W-1:0] SPEED_150  = 3'd1;
  localparam logic [SPEED_W-1:0] SPEED_300  = 3'd2;
  localparam logic [SPEED_W-1:0] SPEED_600  = 3'd3;
  localparam logic [SPEED_W-1:0] SPEED_1200 = 3'd4;

  // Input mode codes
  localparam logic MODE_THROTTLE = 1'b0;
  localparam logic MODE_COMMAND  = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_mode;
    logic [VALUE_W-1:0] throttle_min;
    logic [VALUE_W-1:0] throttle_max;
    logic [TICK_W-1:0]  pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [HIGH_W-1:0]   high0;
    logic [HIGH_W-1:0]   high1;
  } timing_t;

  // Bit period and high times per speed; unknown speeds give zero
  function automatic timing_t bit_timing(input logic [SPEED_W-1:0] speed);
    timing_t t;
    case (speed)
      SPEED_150:  t = '{period: 7'd64, high0: 6'd25, high1: 6'd50};
      SPEED_300:  t = '{period: 7'd32, high0: 6'd12, high1: 6'd24};
      SPEED_600:  t = '{period: 7'd16, high0: 6'd6,  high1: 6'd12};
      SPEED_1200: t = '{period: 7'd8,  high0: 6'd3,  high1: 6'd6};
      default:    t = '{period: 7'd0,  high0: 6'd0,  high1: 6'd0};
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/dsfe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfe_if - valid/ready channels of the DShot frame encoder
// Input channel carries one frame request, output channel one pulse symbol.
// ----------------------------------------------------------------------------
interface dsfe_in_if;
  import dsfe_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [VALUE_W-1:0] value;
  logic               telemetry;

  modport source (output valid, output mode, output value, output telemetry,
                  input ready);
  modport sink   (input valid, input mode, input value, input telemetry,
                  output ready);
endinterface

interface dsfe_out_if;
  import dsfe_pkg::*;

  logic              valid;
  logic              ready;
  logic              first_level;
  logic [TICK_W-1:0] first_ticks;
  logic [LOW_W-1:0]  second_ticks;
  logic              last;

  modport source (output valid, output first_level, output first_ticks,
                  output second_ticks, output last, input ready);
  modport sink   (input valid, input first_level, input first_ticks,
                  input second_ticks, input last, output ready);
endinterface

// ===== hw/rtl/dshot_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_frame_encoder - DShot frame to pulse symbol encoder
// Each request (mode, value, telemetry) becomes a checksummed 16-bit frame
// that leaves as 16 timed data symbols and one end marker.
//
// Usage:
//   in_ch  : valid/ready request channel, one beat per frame.
//   out_ch : valid/ready symbol channel, 17 beats per frame; the end marker
//            has first_level 0, first_ticks = pause_ticks and last set.
//   cfg_*  : write-only register port (speed, clamp limits, pause length),
//            to be written by the user only while no frame is in flight;
//            the block itself does not enforce this.
//   A request passes the front-end frame register, the queue, the emitter's
//   frame shifter and its payload register before its first symbol is valid.
//   Throughput: one symbol per cycle unless out_ch stalls or no frame waits.
//   Requests keep being taken into a two-frame queue while symbols wait.
//   Reset (rst_n low, synchronous) empties the pipeline and queue and loads
//   register defaults: speed off, min 48, max 2047, pause 1000.
//   A stalled out_ch holds its symbol; the emitter and, once the queue
//   fills, the request channel stall behind it without losing a beat.
// ----------------------------------------------------------------------------
module dshot_frame_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dsfe_in_if.sink                         in_ch,
  dsfe_out_if.source                      out_ch
);
  import dsfe_pkg::*;

  cfg_t               cfg_r, cfg_nxt;
  logic               f_valid, f_ready;
  logic [FRAME_W-1:0] f_data;
  logic               q_valid, q_ready;
  logic [FRAME_W-1:0] q_data;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_MODE:   cfg_nxt.speed_mode   = cfg_wdata[SPEED_W-1:0];
        REG_THROTTLE_MIN: cfg_nxt.throttle_min = cfg_wdata[VALUE_W-1:0];
        REG_THROTTLE_MAX: cfg_nxt.throttle_max = cfg_wdata[VALUE_W-1:0];
        REG_PAUSE_TICKS:  cfg_nxt.pause_ticks  = cfg_wdata[TICK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_mode   <= RST_SPEED_MODE;
      cfg_r.throttle_min <= RST_THROTTLE_MIN;
      cfg_r.throttle_max <= RST_THROTTLE_MAX;
      cfg_r.pause_ticks  <= RST_PAUSE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: intake and frame build
  dsfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .frm_valid (f_valid),
    .frm_ready (f_ready),
    .frm_data  (f_data)
  );

  // Frame queue
  dsfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Back end: symbol emission
  dsfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .frm_valid (q_valid),
    .frm_ready (q_ready),
    .frm_data  (q_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== hw/rtl/dsfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfe_front - request intake and frame builder
// Clamps throttle values, appends telemetry and checksum, registers the frame.
// ----------------------------------------------------------------------------
module dsfe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsfe_pkg::cfg_t                cfg,
  dsfe_in_if.sink                       in_ch,
  output logic                          frm_valid,
  input  logic                          frm_ready,
  output logic [dsfe_pkg::FRAME_W-1:0]  frm_data
);
  import dsfe_pkg::*;

  logic               valid_r, valid_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [VALUE_W-1:0] lo_val, clamp_val;
  logic [WORD_W-1:0]  word;
  logic [CSUM_W-1:0]  csum;
  logic               take;

  // Stage holds one frame; refill when empty or when it drains this cycle
  assign in_ch.ready = !valid_r || frm_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Raise to minimum first, then lower to maximum (max wins if min > max); commands pass unclamped
  always_comb begin
    lo_val    = (in_ch.value < cfg.throttle_min) ? cfg.throttle_min : in_ch.value;
    clamp_val = (lo_val > cfg.throttle_max) ? cfg.throttle_max : lo_val;
    if (in_ch.mode == MODE_COMMAND) begin
      clamp_val = in_ch.value;
    end
  end

  // Frame word and nibble checksum
  assign word      = {clamp_val, in_ch.telemetry};
  assign csum      = word[3:0] ^ word[7:4] ^ word[11:8];
  assign frame_nxt = take ? {word, csum} : frame_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (frm_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign frm_valid = valid_r;
  assign frm_data  = frame_r;

endmodule

// ===== hw/rtl/dsfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfe_queue - short frame queue between front and back
// Two-entry FIFO so intake and symbol emission stall independently.
// ----------------------------------------------------------------------------
module dsfe_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_valid,
  output logic                          push_ready,
  input  logic [dsfe_pkg::FRAME_W-1:0]  push_data,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output logic [dsfe_pkg::FRAME_W-1:0]  pop_data
);
  import dsfe_pkg::*;

  logic [FRAME_W-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/dsfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfe_back - pulse symbol emitter
// Shifts a frame out MSB first as timed symbols, then the end marker.
// ----------------------------------------------------------------------------
module dsfe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsfe_pkg::cfg_t                cfg,
  input  logic                          frm_valid,
  output logic                          frm_ready,
  input  logic [dsfe_pkg::FRAME_W-1:0]  frm_data,
  dsfe_out_if.source                    out_ch
);
  import dsfe_pkg::*;

  localparam logic [CNT_W-1:0] END_SYM = CNT_W'(FRAME_BITS);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] shift_r, shift_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic               level_r, last_r;
  logic [TICK_W-1:0]  first_r;
  logic [LOW_W-1:0]   second_r;
  logic               advance, emit, sym_last, pop;
  timing_t            tm;
  logic [HIGH_W-1:0]  hi;
  logic [PERIOD_W-1:0] lo_full;

  // Output register frees when empty or when the beat is taken
  assign advance  = !ovalid_r || out_ch.ready;
  assign emit     = busy_r && advance;
  assign sym_last = (cnt_r == END_SYM);
  assign pop      = frm_valid && (!busy_r || (emit && sym_last));
  assign frm_ready = !busy_r || (emit && sym_last);

  // Symbol timing for the current bit
  always_comb begin
    tm      = bit_timing(cfg.speed_mode);
    hi      = shift_r[FRAME_W-1] ? tm.high1 : tm.high0;
    lo_full = tm.period - PERIOD_W'(hi);
  end

  // Sequencer: load a frame, count 16 data symbols plus the marker
  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    if (pop) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = frm_data;
    end else if (emit) begin
      cnt_nxt   = cnt_r + 1'b1;
      shift_nxt = {shift_r[FRAME_W-2:0], 1'b0};
      if (sym_last) begin
        busy_nxt = 1'b0;
      end
    end
    ovalid_nxt = advance ? busy_r : ovalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Frame shifter and symbol payload register
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (emit) begin
      level_r  <= !sym_last;
      last_r   <= sym_last;
      first_r  <= sym_last ? cfg.pause_ticks : TICK_W'(hi);
      second_r <= sym_last ? '0 : lo_full[LOW_W-1:0];
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.first_level  = level_r;
  assign out_ch.first_ticks  = first_r;
  assign out_ch.second_ticks = second_r;
  assign out_ch.last         = last_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the DShot frame encoder
// Frame requests go in on the request channel. A scoreboard builds each
// expected 16-bit frame (clamp, telemetry, nibble checksum) and its 17 pulse
// symbols, then checks every symbol beat field by field. A short table of
// directed rows runs first, then random requests under random register
// settings. Both channels stall at random, and there is one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
  import dsfe_pkg::*;

  // Run shape
  localparam int NUM_DIR     = 20;
  localparam int NUM_SEG     = 12;
  localparam int SEG_ITEMS   = 35;
  localparam int HOLD_AT     = NUM_DIR + 8 * SEG_ITEMS + 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_TAIL  = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  // Speed codes the package leaves unnamed
  localparam logic [SPEED_W-1:0] SPEED_OFF  = 3'd0;
  localparam logic [SPEED_W-1:0] SPEED_RSV5 = 3'd5;
  localparam logic [SPEED_W-1:0] SPEED_RSV6 = 3'd6;
  localparam logic [SPEED_W-1:0] SPEED_RSV7 = 3'd7;

  // How a table row gets its expected frame
  localparam logic BY_HAND = 1'b1;
  localparam logic PREDICT = 1'b0;

  typedef struct packed {
    logic              first_level;
    logic [TICK_W-1:0] first_ticks;
    logic [LOW_W-1:0]  second_ticks;
    logic              last;
  } pulse_t;

  typedef struct packed {
    logic               by_hand;
    logic [FRAME_W-1:0] frame;
  } hand_frame_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [VALUE_W-1:0] tmin;
    logic [VALUE_W-1:0] tmax;
    logic [TICK_W-1:0]  pause;
    logic               mode;
    logic [VALUE_W-1:0] value;
    logic               tel;
    logic               by_hand;
    logic [FRAME_W-1:0] frame;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dsfe_in_if  in_ch ();
  dsfe_out_if out_ch ();

  dshot_frame_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Scoreboard copy of the registers
  logic [SPEED_W-1:0] cur_speed = RST_SPEED_MODE;
  logic [VALUE_W-1:0] cur_min   = RST_THROTTLE_MIN;
  logic [VALUE_W-1:0] cur_max   = RST_THROTTLE_MAX;
  logic [TICK_W-1:0]  cur_pause = RST_PAUSE_TICKS;

  pulse_t      pending_syms [$];
  hand_frame_t hand_frames [$];
  dir_row_t    dir_tab [NUM_DIR];

  int errors         = 0;
  int frames_in      = 0;
  int syms_out       = 0;
  int inverted_clamp = 0;
  int cycle_count    = 0;
  int in_gap_pct     = 28;
  int out_gap_pct    = 81;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Frame builder: clamp in throttle mode, append telemetry and checksum
  function automatic logic [FRAME_W-1:0] encode_frame(input logic m,
                                                      input logic [VALUE_W-1:0] v,
                                                      input logic t);
    logic [VALUE_W-1:0] x;
    logic [WORD_W-1:0]  w;
    logic [CSUM_W-1:0]  c;
    x = v;
    if (m == MODE_THROTTLE) begin
      if (x < cur_min) x = cur_min;
      if (x > cur_max) x = cur_max;
    end
    w = {x, t};
    c = w[3:0] ^ w[7:4] ^ w[11:8];
    return {w, c};
  endfunction

  // Turn a frame into 16 data symbols, MSB first, plus the end marker
  task automatic expand_frame(input logic [FRAME_W-1:0] f);
    logic [PERIOD_W-1:0] period;
    logic [HIGH_W-1:0]   hi0;
    logic [HIGH_W-1:0]   hi1;
    logic [HIGH_W-1:0]   hi;
    pulse_t              p;
    case (cur_speed)
      SPEED_150:  begin period = 7'd64; hi0 = 6'd25; hi1 = 6'd50; end
      SPEED_300:  begin period = 7'd32; hi0 = 6'd12; hi1 = 6'd24; end
      SPEED_600:  begin period = 7'd16; hi0 = 6'd6;  hi1 = 6'd12; end
      SPEED_1200: begin period = 7'd8;  hi0 = 6'd3;  hi1 = 6'd6;  end
      default:    begin period = '0;    hi0 = '0;    hi1 = '0;    end
    endcase
    for (int k = FRAME_BITS - 1; k >= 0; k--) begin
      hi = f[k] ? hi1 : hi0;
      p.first_level  = 1'b1;
      p.first_ticks  = TICK_W'(hi);
      p.second_ticks = LOW_W'(period - PERIOD_W'(hi));
      p.last         = 1'b0;
      pending_syms.push_back(p);
    end
    p.first_level  = 1'b0;
    p.first_ticks  = cur_pause;
    p.second_ticks = '0;
    p.last         = 1'b1;
    pending_syms.push_back(p);
  endtask

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Register writes, one per cycle; the copy follows once all four are in
  task automatic write_settings(input logic [CFG_DATA_W-1:0] spd,
                                input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] hi,
                                input logic [CFG_DATA_W-1:0] pause);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPEED_MODE;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_index <= REG_THROTTLE_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_THROTTLE_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= REG_PAUSE_TICKS;
    cfg_wdata <= pause;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_speed = spd[SPEED_W-1:0];
    cur_min   = lo[VALUE_W-1:0];
    cur_max   = hi[VALUE_W-1:0];
    cur_pause = pause[TICK_W-1:0];
  endtask

  // One request beat with a random lead-in gap; valid stays up on return
  task automatic send_request(input logic m, input logic [VALUE_W-1:0] v,
                              input logic t, input logic by_hand,
                              input logic [FRAME_W-1:0] f);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    hand_frames.push_back('{by_hand, f});
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.value     <= v;
    in_ch.telemetry <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Wait until the last request is on the board and its symbols have drained
  task automatic wait_drained();
    do @(posedge clk); while (pending_syms.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Request monitor: predict the symbols of every accepted beat
  always @(posedge clk) begin : req_mon
    hand_frame_t h;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      h = hand_frames.pop_front();
      if (in_ch.mode == MODE_THROTTLE && cur_min > cur_max) inverted_clamp++;
      expand_frame(h.by_hand ? h.frame
                             : encode_frame(in_ch.mode, in_ch.value, in_ch.telemetry));
      frames_in <= frames_in + 1;
    end
  end

  // Symbol monitor: compare each beat with the oldest expectation
  always @(posedge clk) begin : sym_mon
    pulse_t got;
    pulse_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.first_level, out_ch.first_ticks, out_ch.second_ticks, out_ch.last};
      syms_out++;
      if (pending_syms.size() == 0) begin
        report($sformatf("unexpected symbol lvl=%0b ticks=%0d/%0d last=%0b",
                         got.first_level, got.first_ticks, got.second_ticks, got.last));
      end else begin
        want = pending_syms.pop_front();
        if (got.first_level !== want.first_level)
          report($sformatf("symbol %0d first_level got %0b exp %0b",
                           syms_out, got.first_level, want.first_level));
        if (got.first_ticks !== want.first_ticks)
          report($sformatf("symbol %0d first_ticks got %0d exp %0d",
                           syms_out, got.first_ticks, want.first_ticks));
        if (got.second_ticks !== want.second_ticks)
          report($sformatf("symbol %0d second_ticks got %0d exp %0d",
                           syms_out, got.second_ticks, want.second_ticks));
        if (got.last !== want.last)
          report($sformatf("symbol %0d last got %0b exp %0b",
                           syms_out, got.last, want.last));
      end
    end
  end

  // Symbol sink: random backpressure plus one long hold to fill the queue
  always @(posedge clk) begin
    if (!hold_done && frames_in >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_gap_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d symbols outstanding",
               cycle_count, pending_syms.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Main sequence
  initial begin
    dir_row_t                row;
    logic [CFG_DATA_W-1:0]   spd;
    logic [CFG_DATA_W-1:0]   lo;
    logic [CFG_DATA_W-1:0]   hi;
    logic [CFG_DATA_W-1:0]   pause;
    logic [VALUE_W-1:0]      v;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_SPEED_MODE;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_THROTTLE;
    in_ch.value     = '0;
    in_ch.telemetry = 1'b0;

    // speed, min, max, pause | mode, value, tel | expected frame
    dir_tab = '{
      // reset settings: clamp up to 48, full ones, all zero, command max
      '{SPEED_OFF,  11'd48,   11'd2047, 15'd1000,  MODE_THROTTLE, 11'd0,
        1'b0, BY_HAND, 16'h0606},
      '{SPEED_OFF,  11'd48,   11'd2047, 15'd1000,  MODE_THROTTLE, 11'd2047,
        1'b1, BY_HAND, 16'hFFFF},
      '{SPEED_OFF,  11'd48,   11'd2047, 15'd1000,  MODE_COMMAND,  11'd0,
        1'b0, BY_HAND, 16'h0000},
      '{SPEED_OFF,  11'd48,   11'd2047, 15'd1000,  MODE_COMMAND,  11'd2047,
        1'b0, BY_HAND, 16'hFFEE},
      // fastest speed, zero pause, walking patterns
      '{SPEED_1200, 11'd48,   11'd2047, 15'd0,     MODE_COMMAND,  11'd0,
        1'b1, BY_HAND, 16'h0011},
      '{SPEED_1200, 11'd48,   11'd2047, 15'd0,     MODE_COMMAND,  11'd1024,
        1'b0, BY_HAND, 16'h8008},
      '{SPEED_1200, 11'd48,   11'd2047, 15'd0,     MODE_COMMAND,  11'h555,
        1'b0, BY_HAND, 16'hAAAA},
      '{SPEED_1200, 11'd48,   11'd2047, 15'd0,     MODE_COMMAND,  11'h2AA,
        1'b1, BY_HAND, 16'h5555},
      // slowest speed, widest range, longest pause
      '{SPEED_150,  11'd0,    11'd2047, 15'd32767, MODE_THROTTLE, 11'd0,
        1'b0, BY_HAND, 16'h0000},
      '{SPEED_150,  11'd0,    11'd2047, 15'd32767, MODE_THROTTLE, 11'd1234,
        1'b1, PREDICT, 16'h0000},
      // narrow range: clamp low, clamp high, command bypass, on the edge
      '{SPEED_300,  11'd100,  11'd1900, 15'd5,     MODE_THROTTLE, 11'd5,
        1'b0, PREDICT, 16'h0000},
      '{SPEED_300,  11'd100,  11'd1900, 15'd5,     MODE_THROTTLE, 11'd2000,
        1'b1, PREDICT, 16'h0000},
      '{SPEED_300,  11'd100,  11'd1900, 15'd5,     MODE_COMMAND,  11'd5,
        1'b0, PREDICT, 16'h0000},
      '{SPEED_300,  11'd100,  11'd1900, 15'd5,     MODE_THROTTLE, 11'd100,
        1'b0, PREDICT, 16'h0000},
      // minimum above maximum: throttle lands on the maximum
      '{SPEED_600,  11'd1500, 11'd100,  15'd1000,  MODE_THROTTLE, 11'd0,
        1'b0, PREDICT, 16'h0000},
      '{SPEED_600,  11'd1500, 11'd100,  15'd1000,  MODE_THROTTLE, 11'd2047,
        1'b0, PREDICT, 16'h0000},
      '{SPEED_600,  11'd1500, 11'd100,  15'd1000,  MODE_COMMAND,  11'd2047,
        1'b1, BY_HAND, 16'hFFFF},
      // unused speed codes give zero durations
      '{SPEED_RSV5, 11'd2047, 11'd2047, 15'd1,     MODE_THROTTLE, 11'd0,
        1'b1, PREDICT, 16'h0000},
      '{SPEED_RSV7, 11'd0,    11'd0,    15'd0,     MODE_THROTTLE, 11'd2047,
        1'b1, PREDICT, 16'h0000},
      '{SPEED_RSV6, 11'd0,    11'd0,    15'd0,     MODE_COMMAND,  11'h3FF,
        1'b0, PREDICT, 16'h0000}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int k = 0; k < NUM_DIR; k++) begin
      row = dir_tab[k];
      if (row.speed != cur_speed || row.tmin != cur_min || row.tmax != cur_max ||
          row.pause != cur_pause) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        write_settings(CFG_DATA_W'(row.speed), CFG_DATA_W'(row.tmin),
                       CFG_DATA_W'(row.tmax), CFG_DATA_W'(row.pause));
      end
      send_request(row.mode, row.value, row.tel, row.by_hand, row.frame);
    end

    // Random segments, each under fresh register settings
    for (int seg = 0; seg < NUM_SEG; seg++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      if (seg < 4) begin
        in_gap_pct  = 28;
        out_gap_pct <= 81;
      end else if (seg < 8) begin
        in_gap_pct  = 81;
        out_gap_pct <= 28;
      end else begin
        in_gap_pct  = 0;
        out_gap_pct <= 0;
      end

      // upper data bits are junk the block must drop
      spd = CFG_DATA_W'($urandom);
      spd[SPEED_W-1:0] = ($urandom_range(0, 3) == 0) ?
                         SPEED_W'($urandom_range(SPEED_OFF, SPEED_RSV7)) :
                         SPEED_W'($urandom_range(SPEED_150, SPEED_1200));
      lo = CFG_DATA_W'($urandom);
      lo[VALUE_W-1:0] = pick_limit();
      hi = CFG_DATA_W'($urandom);
      hi[VALUE_W-1:0] = pick_limit();
      case ($urandom_range(0, 4))
        0:       pause = '0;
        1:       pause = '1;
        2:       pause = CFG_DATA_W'($urandom_range(0, 40));
        default: pause = CFG_DATA_W'($urandom);
      endcase
      write_settings(spd, lo, hi, pause);

      for (int n = 0; n < SEG_ITEMS; n++) begin
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = '1;
          2:       v = cur_min;
          3:       v = cur_max;
          4:       v = cur_min - 1'b1;
          5:       v = cur_max + 1'b1;
          default: v = VALUE_W'($urandom);
        endcase
        send_request($urandom_range(0, 1) ? MODE_COMMAND : MODE_THROTTLE, v,
                     1'($urandom_range(0, 1)), PREDICT, '0);
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Ran %0d frames (%0d table rows, rest random over %0d settings), %0d symbols",
             frames_in, NUM_DIR, NUM_SEG, syms_out);
    $display("Speeds 0-7, pause 0 to max, %0d throttle frames with min above max, %0d-cycle hold",
             inverted_clamp, HOLD_CYCLES);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dsfe_pkg.sv
hw/rtl/dsfe_if.sv
hw/rtl/dsfe_front.sv
hw/rtl/dsfe_queue.sv
hw/rtl/dsfe_back.sv
hw/rtl/dshot_frame_encoder.sv
dv/tb_top.sv
